// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Standalone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DWMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dwmd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DWMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dwmd assertion failed");

`endif

// ----- hdl/dwmd_pkg.sv -----
// Shared widths, codes, reset values and control types of the depth window block.
// No dependencies.
package dwmd_pkg;

	localparam int MAX_WINDOW_DIM = 64;
	localparam int COUNTER_BITS   = 32;
	localparam int COORD_BITS     = 12;

	localparam int DEPTH_BITS    = 16;
	localparam int DIM_BITS      = 13;
	localparam int WIN_BITS      = 7;
	localparam int TRIG_BITS     = 16;
	localparam int SUM_BITS      = 28;
	localparam int CNT_BITS      = 13;
	localparam int AVG_BITS      = 16;
	localparam int TOTAL_BITS    = 32;
	localparam int EV_BITS       = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int STEP_BITS     = $clog2(SUM_BITS);

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
	localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};
	localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FWIDTH   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FHEIGHT  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WWIDTH   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WHEIGHT  = 3'd4;

	// register reset values
	localparam logic [TRIG_BITS-1:0] TRIGGER_RST = 16'd1500;
	localparam logic [DIM_BITS-1:0]  FWIDTH_RST  = 13'd320;
	localparam logic [DIM_BITS-1:0]  FHEIGHT_RST = 13'd288;
	localparam logic [WIN_BITS-1:0]  WWIDTH_RST  = 7'd20;
	localparam logic [WIN_BITS-1:0]  WHEIGHT_RST = 7'd10;

	// event codes
	localparam logic [EV_BITS-1:0] EV_NONE = 2'd0;
	localparam logic [EV_BITS-1:0] EV_L2R  = 2'd1;
	localparam logic [EV_BITS-1:0] EV_R2L  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_DECIDE
	} dwmd_state_t;

	typedef struct packed {
		logic acc_en;      // pixel accepted, accumulate it
		logic div_start;   // load both dividers
		logic frame_done;  // decide, load frame result, clear accumulators
		logic report;      // load report result, clear counters
	} dwmd_cmd_t;

	typedef struct packed {
		logic div_done;
	} dwmd_sts_t;

endpackage

// ----- hdl/dwmd_if.sv -----
// Handshake channel interfaces: pixel input, result output, register write.
// Depends on dwmd_pkg.
interface dwmd_in_if;
	import dwmd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [DEPTH_BITS-1:0] depth;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic                  last_in_frame;
	modport source (output valid, cmd, depth, col, row, last_in_frame, input ready);
	modport sink (input valid, cmd, depth, col, row, last_in_frame, output ready);
endinterface

interface dwmd_out_if;
	import dwmd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  is_report;
	logic [EV_BITS-1:0]    event_res;
	logic [AVG_BITS-1:0]   left_average;
	logic [AVG_BITS-1:0]   right_average;
	logic [TOTAL_BITS-1:0] left_to_right_total;
	logic [TOTAL_BITS-1:0] right_to_left_total;
	modport source (output valid, is_report, event_res, left_average, right_average,
		left_to_right_total, right_to_left_total, input ready);
	modport sink (input valid, is_report, event_res, left_average, right_average,
		left_to_right_total, right_to_left_total, output ready);
endinterface

interface dwmd_cfg_if;
	import dwmd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  idx;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// ----- hdl/dwmd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the window averages.
// Depends on dwmd_pkg.
module dwmd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dwmd_pkg::SUM_BITS-1:0]   dividend,
	input  logic [dwmd_pkg::CNT_BITS-1:0]   divisor,
	output logic [dwmd_pkg::SUM_BITS-1:0]   quotient,
	output logic                            done
);
	import dwmd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]   div_q;
	logic [CNT_BITS:0]     shifted;
	logic                  fits;

	assign shifted = {rem_q, quo_q[SUM_BITS-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_BITS'(SUM_BITS - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? CNT_BITS'(shifted - {1'b0, div_q}) : shifted[CNT_BITS-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- hdl/dwmd_dp.sv -----
// Datapath: registers, window accumulators, dividers, decision, result register.
// Depends on dwmd_pkg and dwmd_div.
module dwmd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dwmd_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [dwmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [dwmd_pkg::DEPTH_BITS-1:0]     depth,
	input  logic [dwmd_pkg::COORD_BITS-1:0]     col,
	input  logic [dwmd_pkg::COORD_BITS-1:0]     row,
	input  dwmd_pkg::dwmd_cmd_t                 cmd,
	output dwmd_pkg::dwmd_sts_t                 sts,
	output logic                                is_report,
	output logic [dwmd_pkg::EV_BITS-1:0]        event_res,
	output logic [dwmd_pkg::AVG_BITS-1:0]       left_average,
	output logic [dwmd_pkg::AVG_BITS-1:0]       right_average,
	output logic [dwmd_pkg::TOTAL_BITS-1:0]     left_to_right_total,
	output logic [dwmd_pkg::TOTAL_BITS-1:0]     right_to_left_total
);
	import dwmd_pkg::*;

	localparam int CMP_BITS = COORD_BITS + 2;

	logic [TRIG_BITS-1:0] trig_q;
	logic [DIM_BITS-1:0]  fw_q;
	logic [DIM_BITS-1:0]  fh_q;
	logic [WIN_BITS-1:0]  ww_q;
	logic [WIN_BITS-1:0]  wh_q;

	logic [SUM_BITS-1:0]     lsum_q, rsum_q;
	logic [CNT_BITS-1:0]     lcnt_q, rcnt_q;
	logic                    flag_q;
	logic [COUNTER_BITS-1:0] l2r_q, r2l_q;

	logic [WIN_BITS-1:0] ww_c, wh_c, ww2;
	logic [CMP_BITS-1:0] cx, cy, hh, span, col_x, row_x;
	logic                in_frame, row_ok, pix_ok, hit_l, hit_r;
	logic [SUM_BITS:0]   lsum_add, rsum_add;

	logic [SUM_BITS-1:0] lquo, rquo;
	logic                ldone, rdone;
	logic [AVG_BITS-1:0] la, ra;

	logic                    flag_n;
	logic [COUNTER_BITS-1:0] l2r_n, r2l_n;
	logic [EV_BITS-1:0]      ev_n;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= TRIGGER_RST;
			fw_q   <= FWIDTH_RST;
			fh_q   <= FHEIGHT_RST;
			ww_q   <= WWIDTH_RST;
			wh_q   <= WHEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TRIGGER: trig_q <= cfg_data[TRIG_BITS-1:0];
				CFG_FWIDTH:  fw_q   <= cfg_data[DIM_BITS-1:0];
				CFG_FHEIGHT: fh_q   <= cfg_data[DIM_BITS-1:0];
				CFG_WWIDTH:  ww_q   <= cfg_data[WIN_BITS-1:0];
				CFG_WHEIGHT: wh_q   <= cfg_data[WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// window geometry; compares are rearranged so nothing goes negative
	assign ww_c  = (ww_q > WIN_BITS'(MAX_WINDOW_DIM)) ? WIN_BITS'(MAX_WINDOW_DIM) : ww_q;
	assign wh_c  = (wh_q > WIN_BITS'(MAX_WINDOW_DIM)) ? WIN_BITS'(MAX_WINDOW_DIM) : wh_q;
	assign ww2   = {ww_c[WIN_BITS-1:1], 1'b0};
	assign span  = CMP_BITS'(ww2);
	assign hh    = CMP_BITS'(wh_c[WIN_BITS-1:1]);
	assign cx    = CMP_BITS'(fw_q[DIM_BITS-1:1]);
	assign cy    = CMP_BITS'(fh_q[DIM_BITS-1:1]);
	assign col_x = CMP_BITS'(col);
	assign row_x = CMP_BITS'(row);

	assign in_frame = ({1'b0, col} < fw_q) && ({1'b0, row} < fh_q);
	assign row_ok   = (row_x + hh >= cy) && (row_x < cy + hh);
	assign pix_ok   = cmd.acc_en && in_frame && row_ok && (depth != '0);
	// left spans [cx - 2hw, cx), right spans [cx, cx + 2hw)
	assign hit_l  = pix_ok && (col_x + span >= cx) && (col_x < cx);
	assign hit_r  = pix_ok && (col_x >= cx) && (col_x < cx + span);

	assign lsum_add = {1'b0, lsum_q} + (SUM_BITS+1)'(depth);
	assign rsum_add = {1'b0, rsum_q} + (SUM_BITS+1)'(depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			lcnt_q <= '0;
			rsum_q <= '0;
			rcnt_q <= '0;
		end else if (cmd.frame_done) begin
			lsum_q <= '0;
			lcnt_q <= '0;
			rsum_q <= '0;
			rcnt_q <= '0;
		end else begin
			if (hit_l) begin
				lsum_q <= lsum_add[SUM_BITS] ? SUM_MAX : lsum_add[SUM_BITS-1:0];
				if (lcnt_q != CNT_MAX)
					lcnt_q <= lcnt_q + 1'b1;
			end
			if (hit_r) begin
				rsum_q <= rsum_add[SUM_BITS] ? SUM_MAX : rsum_add[SUM_BITS-1:0];
				if (rcnt_q != CNT_MAX)
					rcnt_q <= rcnt_q + 1'b1;
			end
		end
	end

	dwmd_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (lsum_q),
		.divisor  (lcnt_q),
		.quotient (lquo),
		.done     (ldone)
	);

	dwmd_div u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rsum_q),
		.divisor  (rcnt_q),
		.quotient (rquo),
		.done     (rdone)
	);

	assign sts.div_done = ldone && rdone;

	// empty window reads 0, large quotients clamp
	assign la = (lcnt_q == '0) ? '0 :
		((lquo > SUM_BITS'(AVG_MAX)) ? AVG_MAX : lquo[AVG_BITS-1:0]);
	assign ra = (rcnt_q == '0) ? '0 :
		((rquo > SUM_BITS'(AVG_MAX)) ? AVG_MAX : rquo[AVG_BITS-1:0]);

	always_comb begin
		flag_n = flag_q;
		l2r_n  = l2r_q;
		r2l_n  = r2l_q;
		ev_n   = EV_NONE;
		if (la != '0 && ra != '0) begin
			if (la < trig_q && ra < trig_q) begin
				flag_n = 1'b1;
			end else if (flag_q) begin
				flag_n = 1'b0;
				if (la < ra) begin
					ev_n = EV_R2L;
					if (r2l_q != CTR_MAX)
						r2l_n = r2l_q + 1'b1;
				end else begin
					ev_n = EV_L2R;
					if (l2r_q != CTR_MAX)
						l2r_n = l2r_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			l2r_q  <= '0;
			r2l_q  <= '0;
		end else if (cmd.frame_done) begin
			flag_q <= flag_n;
			l2r_q  <= l2r_n;
			r2l_q  <= r2l_n;
		end else if (cmd.report) begin
			l2r_q <= '0;
			r2l_q <= '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.frame_done) begin
			is_report           <= 1'b0;
			event_res           <= ev_n;
			left_average        <= la;
			right_average       <= ra;
			left_to_right_total <= TOTAL_BITS'(l2r_n);
			right_to_left_total <= TOTAL_BITS'(r2l_n);
		end else if (cmd.report) begin
			is_report           <= 1'b1;
			event_res           <= EV_NONE;
			left_average        <= '0;
			right_average       <= '0;
			left_to_right_total <= TOTAL_BITS'(l2r_q);
			right_to_left_total <= TOTAL_BITS'(r2l_q);
		end
	end

endmodule

// ----- hdl/dwmd_ctrl.sv -----
// Controller: sequences accept, divide and decide; owns the result valid flag.
// Depends on dwmd_pkg.
module dwmd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_cmd,
	input  logic                 pix_last,
	input  logic                 res_ready,
	input  dwmd_pkg::dwmd_sts_t  sts,
	output logic                 pix_ready,
	output logic                 res_valid,
	output dwmd_pkg::dwmd_cmd_t  cmd
);
	import dwmd_pkg::*;

	dwmd_state_t state_q, state_n;
	logic        res_valid_q;
	logic        slot_free;
	logic        pix_acc;

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (pix_acc && !pix_cmd && pix_last) state_n = ST_START;
			ST_START:  state_n = ST_DIV;
			ST_DIV:    if (sts.div_done) state_n = ST_DECIDE;
			ST_DECIDE: if (slot_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pix_ready      = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE:   pix_ready = !pix_cmd || slot_free;
			ST_START:  cmd.div_start = 1'b1;
			ST_DECIDE: cmd.frame_done = slot_free;
			default: ;
		endcase
		cmd.acc_en = pix_acc && !pix_cmd;
		cmd.report = pix_acc && pix_cmd;
	end

	assign pix_acc = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.frame_done || cmd.report)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ----- hdl/depth_window_motion_direction_top.sv -----
// Top level of the depth window motion direction detector.
// Depends on dwmd_pkg, dwmd_if, dwmd_ctrl, dwmd_dp.

// Pixels (cmd 0) stream in on pix and are taken one per cycle; a pixel is
// summed into the left and/or right window when it lies in the frame, in the
// window rows and columns and has nonzero depth. The pixel flagged
// last_in_frame ends the frame: the block then stops taking items while it
// loads the bit-serial average dividers, waits for them and takes the
// decision, and also while the result register is still held by the sink.
// It then emits one frame result with both averages, the direction event and
// the movement totals, and clears the windows. A report item (cmd 1) is
// answered in the next cycle with the two saturating totals, which then
// clear; it waits while a frame is being closed or while the result
// register is full and not being drained. Registers on cfg are always
// writable (ready held high) and must be written only while no frame is
// being closed. No clearing pass after reset: the block is ready at once.
module depth_window_motion_direction_top (
	input  logic        clk,
	input  logic        arst_n,
	dwmd_in_if.sink     pix,
	dwmd_out_if.source  res,
	dwmd_cfg_if.sink    cfg
);
	import dwmd_pkg::*;

	dwmd_cmd_t cmd;
	dwmd_sts_t sts;

	// register writes never stall
	assign cfg.ready = 1'b1;

	dwmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_cmd   (pix.cmd),
		.pix_last  (pix.last_in_frame),
		.res_ready (res.ready),
		.sts       (sts),
		.pix_ready (pix.ready),
		.res_valid (res.valid),
		.cmd       (cmd)
	);

	dwmd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg.valid),
		.cfg_idx             (cfg.idx),
		.cfg_data            (cfg.data),
		.depth               (pix.depth),
		.col                 (pix.col),
		.row                 (pix.row),
		.cmd                 (cmd),
		.sts                 (sts),
		.is_report           (res.is_report),
		.event_res           (res.event_res),
		.left_average        (res.left_average),
		.right_average       (res.right_average),
		.left_to_right_total (res.left_to_right_total),
		.right_to_left_total (res.right_to_left_total)
	);

endmodule

// ----- hdl/dwmd_checker.sv -----
// Port-level checks of the depth window block, bound onto the top level.
// Depends on dwmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwmd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pix_valid,
	input logic                            pix_ready,
	input logic                            pix_cmd,
	input logic                            pix_last,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            res_is_report,
	input logic [dwmd_pkg::EV_BITS-1:0]    res_event,
	input logic [dwmd_pkg::AVG_BITS-1:0]   res_left_avg,
	input logic [dwmd_pkg::AVG_BITS-1:0]   res_right_avg
);
	import dwmd_pkg::*;

	logic rpt_acc, end_acc;

	assign rpt_acc = pix_valid && pix_ready && pix_cmd;
	assign end_acc = pix_valid && pix_ready && !pix_cmd && pix_last;

	// a pending result is never dropped
	`DWMD_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	// a report is answered in the very next cycle
	`DWMD_ASSERT_NXT(a_rpt_next, clk, arst_n, rpt_acc, res_valid && res_is_report)
	// the input is closed right after the frame end is accepted
	`DWMD_ASSERT_NXT(a_end_busy, clk, arst_n, end_acc, !pix_ready)
	// report results carry no event or averages
	`DWMD_ASSERT_IMP(a_rpt_zero, clk, arst_n, res_valid && res_is_report,
		res_event == EV_NONE && res_left_avg == '0 && res_right_avg == '0)

endmodule

bind depth_window_motion_direction_top dwmd_checker u_dwmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_cmd       (pix.cmd),
	.pix_last      (pix.last_in_frame),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_is_report (res.is_report),
	.res_event     (res.event_res),
	.res_left_avg  (res.left_average),
	.res_right_avg (res.right_average)
);
